@@ src/assert_macros.svh @@
// Assertion macros shared by the evaluator RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is high
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Plain invariant checked at every edge out of reset
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   `ASSERT_PROP(label, clk, rst, expr, msg)

`endif

@@ src/rshe_pkg.sv @@
// Shared types, constants and helpers for the spherical harmonic evaluator
package rshe_pkg;

   // fixed-point geometry
   localparam int NORM_BITS = 31;
   localparam int UNIT_BITS = 30;
   localparam int ROOT_BITS = 32;
   localparam int RAD_BITS  = 2 * ROOT_BITS;
   localparam int QUO_BITS  = 31;
   localparam int DVD_BITS  = QUO_BITS + ROOT_BITS - 1;
   localparam int POLY_W    = 36;
   localparam int VALUE_W   = 32;

   localparam logic [63:0] HALF_UNIT = 64'(1) << (UNIT_BITS - 1);

   // result status codes
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_ORIGIN    = 2'd1,
      ST_BAD_ORDER = 2'd2
   } status_type;

   // register map
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_DEGREE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORDER  = 1'd1;

   // normalisation constant selectors
   localparam int NUM_CONSTS = 10;
   localparam int K_W = $clog2(NUM_CONSTS);
   localparam logic [K_W-1:0] K_L0     = 4'd0;
   localparam logic [K_W-1:0] K_L1     = 4'd1;
   localparam logic [K_W-1:0] K_L2_MIX = 4'd2;
   localparam logic [K_W-1:0] K_L2_M0  = 4'd3;
   localparam logic [K_W-1:0] K_L2_M2  = 4'd4;
   localparam logic [K_W-1:0] K_L3_M3  = 4'd5;
   localparam logic [K_W-1:0] K_L3_MN2 = 4'd6;
   localparam logic [K_W-1:0] K_L3_M1  = 4'd7;
   localparam logic [K_W-1:0] K_L3_M0  = 4'd8;
   localparam logic [K_W-1:0] K_L3_M2  = 4'd9;

   // decimal constants scaled by 10^17
   localparam logic [63:0] DEC_ONE = 64'd100000000000000000;
   localparam logic [63:0] DEC_CONSTS [NUM_CONSTS] = '{
      64'd28209479177387814,
      64'd48860251190291992,
      64'd109254843059207907,
      64'd31539156525252000,
      64'd54627421529603953,
      64'd59004358992664351,
      64'd289061144264055405,
      64'd45704579946446573,
      64'd37317633259011539,
      64'd144530572132027702
   };

   // decimal to Q30, rounded half up (elaboration only)
   function automatic logic [31:0] qconst(input logic [63:0] n);
      logic [63:0] q;
      logic [63:0] r;
      q = n / DEC_ONE;
      r = n % DEC_ONE;
      for (int i = 0; i < UNIT_BITS; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= DEC_ONE) begin
            q[0] = 1'b1;
            r    = r - DEC_ONE;
         end
      end
      if ((r << 1) >= DEC_ONE) q = q + 64'd1;
      return q[31:0];
   endfunction

   localparam logic [31:0] QCONST [NUM_CONSTS] = '{
      qconst(DEC_CONSTS[0]), qconst(DEC_CONSTS[1]), qconst(DEC_CONSTS[2]),
      qconst(DEC_CONSTS[3]), qconst(DEC_CONSTS[4]), qconst(DEC_CONSTS[5]),
      qconst(DEC_CONSTS[6]), qconst(DEC_CONSTS[7]), qconst(DEC_CONSTS[8]),
      qconst(DEC_CONSTS[9])
   };

   // Q60 product back to Q30, half away from zero
   function automatic logic signed [POLY_W-1:0] mulq_rnd(input logic signed [63:0] p);
      logic [63:0] mag;
      logic [63:0] t;
      mag = p[63] ? 64'(-p) : 64'(p);
      t   = (mag + HALF_UNIT) >> UNIT_BITS;
      return p[63] ? signed'(POLY_W'(0) - POLY_W'(t)) : signed'(POLY_W'(t));
   endfunction

   // per-item tag that rides the whole pipe
   typedef struct packed {
      status_type status;
      logic       last;
   } tag_type;

   // side payload through the square root
   typedef struct packed {
      logic [2:0][NORM_BITS-1:0] nmag;
      logic [2:0]                neg;
      tag_type                   tag;
   } root_ctx_type;

   // side payload through the divider
   typedef struct packed {
      logic [2:0] neg;
      tag_type    tag;
   } div_ctx_type;

endpackage

@@ src/rshe_isqrt.sv @@
// Pipelined integer square root, one root bit per register stage
module rshe_isqrt #(
   parameter int ROOT_BITS = 32,
   parameter int SIDE_W    = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [2*ROOT_BITS-1:0] in_rad,
   input  logic [SIDE_W-1:0]      in_side,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [ROOT_BITS-1:0]   out_root,
   output logic [SIDE_W-1:0]      out_side
);

   localparam int RADW = 2 * ROOT_BITS;
   localparam int RW   = ROOT_BITS + 2;

   logic [ROOT_BITS-1:0] v_ff;
   logic [ROOT_BITS:0]   rdy;
   logic [ROOT_BITS-1:0] rem_ff  [ROOT_BITS];
   logic [ROOT_BITS-1:0] root_ff [ROOT_BITS];
   logic [RADW-1:0]      rad_ff  [ROOT_BITS];
   logic [SIDE_W-1:0]    side_ff [ROOT_BITS];

   assign rdy[ROOT_BITS] = out_ready;

   for (genvar j = 0; j < ROOT_BITS; j++) begin : g_stage
      logic                 v_prev;
      logic [ROOT_BITS-1:0] rem_prev;
      logic [ROOT_BITS-1:0] root_prev;
      logic [RADW-1:0]      rad_prev;
      logic [SIDE_W-1:0]    side_prev;
      logic [RW-1:0]        cur;
      logic [RW-1:0]        trial;
      logic                 ge;
      logic [ROOT_BITS-1:0] rem_in;
      logic [ROOT_BITS-1:0] root_in;

      if (j == 0) begin : g_first
         assign v_prev    = in_valid;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = in_rad;
         assign side_prev = in_side;
      end else begin : g_next
         assign v_prev    = v_ff[j-1];
         assign rem_prev  = rem_ff[j-1];
         assign root_prev = root_ff[j-1];
         assign rad_prev  = rad_ff[j-1];
         assign side_prev = side_ff[j-1];
      end

      // bring down two radicand bits, try root*4+1
      always_comb begin
         cur     = {rem_prev, rad_prev[RADW-1 -: 2]};
         trial   = {root_prev, 2'b01};
         ge      = (cur >= trial);
         rem_in  = ge ? ROOT_BITS'(cur - trial) : ROOT_BITS'(cur);
         root_in = {root_prev[ROOT_BITS-2:0], ge};
      end

      assign rdy[j] = !v_ff[j] || rdy[j+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else if (rdy[j]) begin
            v_ff[j] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[j]) begin
            rem_ff[j]  <= rem_in;
            root_ff[j] <= root_in;
            rad_ff[j]  <= rad_prev << 2;
            side_ff[j] <= side_prev;
         end
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[ROOT_BITS-1];
   assign out_root  = root_ff[ROOT_BITS-1];
   assign out_side  = side_ff[ROOT_BITS-1];

endmodule

@@ src/rshe_div.sv @@
// Pipelined restoring divider, shared divisor, one quotient bit per stage
module rshe_div #(
   parameter int LANES    = 3,
   parameter int QUO_BITS = 31,
   parameter int DVS_BITS = 32,
   parameter int SIDE_W   = 8
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        in_valid,
   output logic                                        in_ready,
   input  logic [DVS_BITS-1:0]                         in_divisor,
   input  logic [LANES-1:0][QUO_BITS+DVS_BITS-2:0]     in_dividend,
   input  logic [SIDE_W-1:0]                           in_side,
   output logic                                        out_valid,
   input  logic                                        out_ready,
   output logic [LANES-1:0][QUO_BITS-1:0]              out_quo,
   output logic [SIDE_W-1:0]                           out_side
);

   localparam int DVDW = QUO_BITS + DVS_BITS - 1;

   logic [QUO_BITS-1:0]                v_ff;
   logic [QUO_BITS:0]                  rdy;
   logic [DVS_BITS-1:0]                dvs_ff  [QUO_BITS];
   logic [LANES-1:0][DVS_BITS-1:0]     rem_ff  [QUO_BITS];
   logic [LANES-1:0][QUO_BITS-1:0]     lo_ff   [QUO_BITS];
   logic [SIDE_W-1:0]                  side_ff [QUO_BITS];

   assign rdy[QUO_BITS] = out_ready;

   for (genvar j = 0; j < QUO_BITS; j++) begin : g_stage
      logic                            v_prev;
      logic [DVS_BITS-1:0]             dvs_prev;
      logic [LANES-1:0][DVS_BITS-1:0]  rem_prev;
      logic [LANES-1:0][QUO_BITS-1:0]  lo_prev;
      logic [SIDE_W-1:0]               side_prev;
      logic [LANES-1:0][DVS_BITS-1:0]  rem_in;
      logic [LANES-1:0][QUO_BITS-1:0]  lo_in;

      if (j == 0) begin : g_first
         assign v_prev    = in_valid;
         assign dvs_prev  = in_divisor;
         assign side_prev = in_side;
         for (genvar n = 0; n < LANES; n++) begin : g_lane
            assign rem_prev[n] = DVS_BITS'(in_dividend[n][DVDW-1:QUO_BITS]);
            assign lo_prev[n]  = in_dividend[n][QUO_BITS-1:0];
         end
      end else begin : g_next
         assign v_prev    = v_ff[j-1];
         assign dvs_prev  = dvs_ff[j-1];
         assign rem_prev  = rem_ff[j-1];
         assign lo_prev   = lo_ff[j-1];
         assign side_prev = side_ff[j-1];
      end

      // shift in the next dividend bit, subtract where it fits
      always_comb begin
         for (int n = 0; n < LANES; n++) begin
            logic [DVS_BITS:0] cur;
            logic              ge;
            cur       = {rem_prev[n], lo_prev[n][QUO_BITS-1]};
            ge        = (cur >= {1'b0, dvs_prev});
            rem_in[n] = ge ? DVS_BITS'(cur - {1'b0, dvs_prev}) : DVS_BITS'(cur);
            lo_in[n]  = {lo_prev[n][QUO_BITS-2:0], ge};
         end
      end

      assign rdy[j] = !v_ff[j] || rdy[j+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else if (rdy[j]) begin
            v_ff[j] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[j]) begin
            dvs_ff[j]  <= dvs_prev;
            rem_ff[j]  <= rem_in;
            lo_ff[j]   <= lo_in;
            side_ff[j] <= side_prev;
         end
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[QUO_BITS-1];
   assign out_quo   = lo_ff[QUO_BITS-1];
   assign out_side  = side_ff[QUO_BITS-1];

endmodule

@@ src/real_spherical_harmonic_eval_top.sv @@
// Real spherical harmonic evaluator for degrees 0 to 3, streaming one point per clock
// while the result stream is not stalled. Each point (x, y, z) goes in as one word and
// comes out as one word of the harmonic for the programmed degree and order, signed with
// RESULT_FRAC_BITS fraction bits, plus a status (ok, point at origin, order out of range)
// and the frame marker. Stages: magnitude, bit length, normalise, squares, sum of squares,
// the bit-per-stage square root, dividends, the bit-per-stage unit-vector divider, then
// polynomial products, constant scaling and output rounding. Each stage holds its word
// independently, so back-pressure only fills bubbles. The user must write degree and
// order through the csr port only while no point is in flight; the block does not enforce it.
`include "assert_macros.svh"

module real_spherical_harmonic_eval_top #(
   parameter int COORD_BITS       = 32,
   parameter int RESULT_FRAC_BITS = 29,
   localparam int REQ_W = ((3 * COORD_BITS + 7) / 8) * 8
) (
   input  logic                            clock,
   input  logic                            reset,
   // input stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [REQ_W-1:0]                req_tdata,  // coord_x, coord_y, coord_z, zero pad
   input  logic                            req_tlast,  // last_point
   // result stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [rshe_pkg::VALUE_W-1:0]    rsp_tdata,  // harmonic_value
   output logic [1:0]                      rsp_tuser,  // status
   output logic                            rsp_tlast,  // last_out
   // register writes
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rshe_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rshe_pkg::CSR_DATA_W-1:0] csr_data
);

   import rshe_pkg::*;

   localparam int LEN_W = $clog2(COORD_BITS + 1);
   localparam int SHIFT = 2 * UNIT_BITS - RESULT_FRAC_BITS;
   localparam logic [63:0] OUT_HALF = 64'(1) << (SHIFT - 1);
   localparam logic signed [POLY_W-1:0] ONE_W = POLY_W'(1) << UNIT_BITS;
   localparam logic [63:0] POS_MAX = 64'h0000_0000_7FFF_FFFF;
   localparam logic [63:0] NEG_MAX = 64'h0000_0000_8000_0000;

   // ---------------- configuration registers ----------------
   logic [1:0]        degree_ff;
   logic signed [2:0] order_ff;
   logic [2:0]        abs_order;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff <= '0;
         order_ff  <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_DEGREE: degree_ff <= csr_data[1:0];
            CSR_ORDER:  order_ff  <= signed'(csr_data);
            default:    ;
         endcase
      end
   end

   assign abs_order = order_ff[2] ? 3'(-order_ff) : 3'(order_ff);

   // ---------------- ready chain ----------------
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff;
   logic v8_ff, v9_ff, v10_ff, v11_ff, v12_ff, v13_ff, v14_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;
   logic rdy8, rdy9, rdy10, rdy11, rdy12, rdy13, rdy14;
   logic sq_in_ready, sq_out_valid, dv_in_ready, dv_out_valid;

   assign rdy14 = !v14_ff || rsp_tready;
   assign rdy13 = !v13_ff || rdy14;
   assign rdy12 = !v12_ff || rdy13;
   assign rdy11 = !v11_ff || rdy12;
   assign rdy10 = !v10_ff || rdy11;
   assign rdy9  = !v9_ff  || rdy10;
   assign rdy8  = !v8_ff  || rdy9;
   assign rdy7  = !v7_ff  || rdy8;
   assign rdy6  = !v6_ff  || dv_in_ready;
   assign rdy5  = !v5_ff  || sq_in_ready;
   assign rdy4  = !v4_ff  || rdy5;
   assign rdy3  = !v3_ff  || rdy4;
   assign rdy2  = !v2_ff  || rdy3;
   assign rdy1  = !v1_ff  || rdy2;
   assign req_tready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         {v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff}    <= '0;
         {v8_ff, v9_ff, v10_ff, v11_ff, v12_ff, v13_ff, v14_ff} <= '0;
      end else begin
         if (rdy1)  v1_ff  <= req_tvalid;
         if (rdy2)  v2_ff  <= v1_ff;
         if (rdy3)  v3_ff  <= v2_ff;
         if (rdy4)  v4_ff  <= v3_ff;
         if (rdy5)  v5_ff  <= v4_ff;
         if (rdy6)  v6_ff  <= sq_out_valid;
         if (rdy7)  v7_ff  <= dv_out_valid;
         if (rdy8)  v8_ff  <= v7_ff;
         if (rdy9)  v9_ff  <= v8_ff;
         if (rdy10) v10_ff <= v9_ff;
         if (rdy11) v11_ff <= v10_ff;
         if (rdy12) v12_ff <= v11_ff;
         if (rdy13) v13_ff <= v12_ff;
         if (rdy14) v14_ff <= v13_ff;
      end
   end

   // ---------------- stage 1: magnitudes, signs, status ----------------
   logic [2:0][COORD_BITS-1:0] mag1_in, mag1_ff;
   logic [2:0]                 neg1_in, neg1_ff;
   logic [COORD_BITS-1:0]      orv1_in, orv1_ff;
   tag_type                    tag1_in, tag1_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic [COORD_BITS-1:0] c;
         c          = req_tdata[i*COORD_BITS +: COORD_BITS];
         neg1_in[i] = c[COORD_BITS-1];
         mag1_in[i] = c[COORD_BITS-1] ? COORD_BITS'(-c) : c;
      end
      orv1_in      = mag1_in[0] | mag1_in[1] | mag1_in[2];
      tag1_in.last = req_tlast;
      if (degree_ff == 2'd0)            tag1_in.status = ST_OK;
      else if (orv1_in == '0)           tag1_in.status = ST_ORIGIN;
      else if (abs_order > {1'b0, degree_ff}) tag1_in.status = ST_BAD_ORDER;
      else                              tag1_in.status = ST_OK;
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         mag1_ff <= mag1_in;
         neg1_ff <= neg1_in;
         orv1_ff <= orv1_in;
         tag1_ff <= tag1_in;
      end
   end

   // ---------------- stage 2: bit length of the largest magnitude ----------------
   logic [2:0][COORD_BITS-1:0] mag2_ff;
   logic [2:0]                 neg2_ff;
   logic [LEN_W-1:0]           len2_in, len2_ff;
   tag_type                    tag2_ff;

   always_comb begin
      len2_in = '0;
      for (int b = 0; b < COORD_BITS; b++) begin
         if (orv1_ff[b]) len2_in = LEN_W'(b + 1);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         mag2_ff <= mag1_ff;
         neg2_ff <= neg1_ff;
         len2_ff <= len2_in;
         tag2_ff <= tag1_ff;
      end
   end

   // ---------------- stage 3: normalise to 31 bits ----------------
   logic [2:0][NORM_BITS-1:0] nmag3_in, nmag3_ff;
   logic [2:0]                neg3_ff;
   tag_type                   tag3_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic [COORD_BITS+NORM_BITS-1:0] w;
         w           = {mag2_ff[i], {NORM_BITS{1'b0}}} >> len2_ff;
         nmag3_in[i] = w[NORM_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         nmag3_ff <= nmag3_in;
         neg3_ff  <= neg2_ff;
         tag3_ff  <= tag2_ff;
      end
   end

   // ---------------- stage 4: squares ----------------
   logic [2:0][2*NORM_BITS-1:0] sq4_ff;
   logic [2:0][NORM_BITS-1:0]   nmag4_ff;
   logic [2:0]                  neg4_ff;
   tag_type                     tag4_ff;

   always_ff @(posedge clock) begin
      if (rdy4) begin
         for (int i = 0; i < 3; i++) begin
            sq4_ff[i] <= (2*NORM_BITS)'(nmag3_ff[i]) * (2*NORM_BITS)'(nmag3_ff[i]);
         end
         nmag4_ff <= nmag3_ff;
         neg4_ff  <= neg3_ff;
         tag4_ff  <= tag3_ff;
      end
   end

   // ---------------- stage 5: sum of squares ----------------
   logic [RAD_BITS-1:0] r2_5_ff;
   root_ctx_type        ctx5_ff;

   always_ff @(posedge clock) begin
      if (rdy5) begin
         r2_5_ff      <= RAD_BITS'(sq4_ff[0]) + RAD_BITS'(sq4_ff[1]) + RAD_BITS'(sq4_ff[2]);
         ctx5_ff.nmag <= nmag4_ff;
         ctx5_ff.neg  <= neg4_ff;
         ctx5_ff.tag  <= tag4_ff;
      end
   end

   // ---------------- radius ----------------
   logic [ROOT_BITS-1:0]            root_q;
   logic [$bits(root_ctx_type)-1:0] sq_side_out;
   root_ctx_type                    ctx_r;

   rshe_isqrt #(
      .ROOT_BITS (ROOT_BITS),
      .SIDE_W    ($bits(root_ctx_type))
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v5_ff),
      .in_ready  (sq_in_ready),
      .in_rad    (r2_5_ff),
      .in_side   (ctx5_ff),
      .out_valid (sq_out_valid),
      .out_ready (rdy6),
      .out_root  (root_q),
      .out_side  (sq_side_out)
   );

   assign ctx_r = root_ctx_type'(sq_side_out);

   // ---------------- stage 6: dividends with half-radius rounding ----------------
   logic [ROOT_BITS-1:0]           r6_ff;
   logic [2:0][DVD_BITS-1:0]       dvd6_ff;
   div_ctx_type                    ctx6_ff;

   always_ff @(posedge clock) begin
      if (rdy6) begin
         r6_ff <= root_q;
         for (int i = 0; i < 3; i++) begin
            dvd6_ff[i] <= DVD_BITS'({ctx_r.nmag[i], {UNIT_BITS{1'b0}}})
                        + DVD_BITS'(root_q >> 1);
         end
         ctx6_ff.neg <= ctx_r.neg;
         ctx6_ff.tag <= ctx_r.tag;
      end
   end

   // ---------------- unit vector ----------------
   logic [2:0][QUO_BITS-1:0]       quo;
   logic [$bits(div_ctx_type)-1:0] dv_side_out;
   div_ctx_type                    ctx_d;

   rshe_div #(
      .LANES    (3),
      .QUO_BITS (QUO_BITS),
      .DVS_BITS (ROOT_BITS),
      .SIDE_W   ($bits(div_ctx_type))
   ) u_div (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (v6_ff),
      .in_ready    (dv_in_ready),
      .in_divisor  (r6_ff),
      .in_dividend (dvd6_ff),
      .in_side     (ctx6_ff),
      .out_valid   (dv_out_valid),
      .out_ready   (rdy7),
      .out_quo     (quo),
      .out_side    (dv_side_out)
   );

   assign ctx_d = div_ctx_type'(dv_side_out);

   // ---------------- stage 7: signed unit components ----------------
   logic signed [31:0] ux7_ff, uy7_ff, uz7_ff;
   tag_type            tag7_ff;

   always_ff @(posedge clock) begin
      if (rdy7) begin
         ux7_ff  <= ctx_d.neg[0] ? -signed'({1'b0, quo[0]}) : signed'({1'b0, quo[0]});
         uy7_ff  <= ctx_d.neg[1] ? -signed'({1'b0, quo[1]}) : signed'({1'b0, quo[1]});
         uz7_ff  <= ctx_d.neg[2] ? -signed'({1'b0, quo[2]}) : signed'({1'b0, quo[2]});
         tag7_ff <= ctx_d.tag;
      end
   end

   // ---------------- stage 8: pairwise products ----------------
   logic signed [63:0] pxx8_ff, pyy8_ff, pzz8_ff, pxy8_ff, pyz8_ff, pxz8_ff;
   logic signed [31:0] ux8_ff, uy8_ff, uz8_ff;
   tag_type            tag8_ff;

   always_ff @(posedge clock) begin
      if (rdy8) begin
         pxx8_ff <= 64'(ux7_ff) * 64'(ux7_ff);
         pyy8_ff <= 64'(uy7_ff) * 64'(uy7_ff);
         pzz8_ff <= 64'(uz7_ff) * 64'(uz7_ff);
         pxy8_ff <= 64'(ux7_ff) * 64'(uy7_ff);
         pyz8_ff <= 64'(uy7_ff) * 64'(uz7_ff);
         pxz8_ff <= 64'(ux7_ff) * 64'(uz7_ff);
         ux8_ff  <= ux7_ff;
         uy8_ff  <= uy7_ff;
         uz8_ff  <= uz7_ff;
         tag8_ff <= tag7_ff;
      end
   end

   // ---------------- stage 9: round products to Q30 ----------------
   logic signed [POLY_W-1:0] xx9_ff, yy9_ff, zz9_ff, xy9_ff, yz9_ff, xz9_ff;
   logic signed [31:0]       ux9_ff, uy9_ff, uz9_ff;
   tag_type                  tag9_ff;

   always_ff @(posedge clock) begin
      if (rdy9) begin
         xx9_ff  <= mulq_rnd(pxx8_ff);
         yy9_ff  <= mulq_rnd(pyy8_ff);
         zz9_ff  <= mulq_rnd(pzz8_ff);
         xy9_ff  <= mulq_rnd(pxy8_ff);
         yz9_ff  <= mulq_rnd(pyz8_ff);
         xz9_ff  <= mulq_rnd(pxz8_ff);
         ux9_ff  <= ux8_ff;
         uy9_ff  <= uy8_ff;
         uz9_ff  <= uz8_ff;
         tag9_ff <= tag8_ff;
      end
   end

   // ---------------- stage 10: pick the term for degree and order ----------------
   logic signed [POLY_W-1:0] opa10_in, opa10_ff, dir10_in, dir10_ff;
   logic signed [31:0]       opb10_in, opb10_ff;
   logic                     mul10_in, mul10_ff;
   logic [K_W-1:0]           k10_in, k10_ff;
   tag_type                  tag10_ff;

   always_comb begin
      logic signed [POLY_W-1:0] ux_w, uy_w, uz_w, zz5, xx_m_yy;
      ux_w     = POLY_W'(ux9_ff);
      uy_w     = POLY_W'(uy9_ff);
      uz_w     = POLY_W'(uz9_ff);
      zz5      = (zz9_ff <<< 2) + zz9_ff;
      xx_m_yy  = xx9_ff - yy9_ff;
      opa10_in = '0;
      opb10_in = '0;
      dir10_in = ONE_W;
      mul10_in = 1'b0;
      k10_in   = K_L0;
      case (degree_ff)
         2'd1: begin
            k10_in = K_L1;
            if (order_ff < 0)       dir10_in = -uy_w;
            else if (order_ff == 0) dir10_in = uz_w;
            else                    dir10_in = -ux_w;
         end
         2'd2: begin
            case (order_ff)
               -3'sd2: begin k10_in = K_L2_MIX; dir10_in = xy9_ff; end
               -3'sd1: begin k10_in = K_L2_MIX; dir10_in = -yz9_ff; end
               3'sd0:  begin k10_in = K_L2_M0;  dir10_in = (zz9_ff <<< 1) + zz9_ff - ONE_W; end
               3'sd1:  begin k10_in = K_L2_MIX; dir10_in = -xz9_ff; end
               default: begin k10_in = K_L2_M2; dir10_in = xx_m_yy; end
            endcase
         end
         2'd3: begin
            mul10_in = 1'b1;
            case (order_ff)
               -3'sd3: begin
                  k10_in = K_L3_M3;  opa10_in = (xx9_ff <<< 1) + xx9_ff - yy9_ff;
                  opb10_in = uy9_ff;
               end
               -3'sd2: begin k10_in = K_L3_MN2; opa10_in = xy9_ff; opb10_in = uz9_ff; end
               -3'sd1: begin k10_in = K_L3_M1; opa10_in = zz5 - ONE_W; opb10_in = uy9_ff; end
               3'sd0: begin
                  k10_in = K_L3_M0; opa10_in = zz5 - ((ONE_W <<< 1) + ONE_W);
                  opb10_in = uz9_ff;
               end
               3'sd1:  begin k10_in = K_L3_M1; opa10_in = zz5 - ONE_W; opb10_in = ux9_ff; end
               3'sd2:  begin k10_in = K_L3_M2; opa10_in = xx_m_yy; opb10_in = uz9_ff; end
               default: begin
                  k10_in = K_L3_M3; opa10_in = xx9_ff - ((yy9_ff <<< 1) + yy9_ff);
                  opb10_in = ux9_ff;
               end
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (rdy10) begin
         opa10_ff <= opa10_in;
         opb10_ff <= opb10_in;
         dir10_ff <= dir10_in;
         mul10_ff <= mul10_in;
         k10_ff   <= k10_in;
         tag10_ff <= tag9_ff;
      end
   end

   // ---------------- stage 11: degree-3 product ----------------
   logic signed [63:0]       prod11_ff;
   logic signed [POLY_W-1:0] dir11_ff;
   logic                     mul11_ff;
   logic [K_W-1:0]           k11_ff;
   tag_type                  tag11_ff;

   always_ff @(posedge clock) begin
      if (rdy11) begin
         prod11_ff <= 64'(opa10_ff) * 64'(opb10_ff);
         dir11_ff  <= dir10_ff;
         mul11_ff  <= mul10_ff;
         k11_ff    <= k10_ff;
         tag11_ff  <= tag10_ff;
      end
   end

   // ---------------- stage 12: polynomial magnitude and sign ----------------
   logic [31:0]    pm12_ff;
   logic           pneg12_ff;
   logic [K_W-1:0] k12_ff;
   tag_type        tag12_ff;

   always_ff @(posedge clock) begin
      logic signed [POLY_W-1:0] poly;
      logic signed [POLY_W-1:0] pabs;
      if (rdy12) begin
         poly      = mul11_ff ? mulq_rnd(prod11_ff) : dir11_ff;
         pabs      = poly[POLY_W-1] ? -poly : poly;
         pm12_ff   <= pabs[31:0];
         pneg12_ff <= poly[POLY_W-1];
         k12_ff    <= k11_ff;
         tag12_ff  <= tag11_ff;
      end
   end

   // ---------------- stage 13: scale by normalisation constant ----------------
   logic [63:0] cm13_ff;
   logic        pneg13_ff;
   tag_type     tag13_ff;

   always_ff @(posedge clock) begin
      if (rdy13) begin
         cm13_ff   <= 64'(QCONST[k12_ff]) * 64'(pm12_ff);
         pneg13_ff <= pneg12_ff;
         tag13_ff  <= tag12_ff;
      end
   end

   // ---------------- stage 14: round, saturate, output word ----------------
   logic [VALUE_W-1:0] hv14_in, hv14_ff;
   tag_type            tag14_ff;

   always_comb begin
      logic [63:0] qv;
      logic [63:0] clamped;
      qv = (cm13_ff + OUT_HALF) >> SHIFT;
      if (pneg13_ff) begin
         clamped = (qv > NEG_MAX) ? NEG_MAX : qv;
         hv14_in = VALUE_W'(64'd0 - clamped);
      end else begin
         clamped = (qv > POS_MAX) ? POS_MAX : qv;
         hv14_in = VALUE_W'(clamped);
      end
      if (tag13_ff.status != ST_OK) hv14_in = '0;
   end

   always_ff @(posedge clock) begin
      if (rdy14) begin
         hv14_ff  <= hv14_in;
         tag14_ff <= tag13_ff;
      end
   end

   assign rsp_tvalid = v14_ff;
   assign rsp_tdata  = hv14_ff;
   assign rsp_tuser  = tag14_ff.status;
   assign rsp_tlast  = tag14_ff.last;

   // ---------------- checks ----------------
   `ASSERT_PROP(a_flagged_zero, clock, reset,
      rsp_tvalid && (rsp_tuser != ST_OK) |-> (rsp_tdata == '0), "flagged word carries a value")
   `ASSERT_ALWAYS(a_empty_out_ready, clock, reset,
      rsp_tvalid || req_tready, "input stalled with empty output stage")
   `ASSERT_PROP(a_scale_hold, clock, reset,
      v13_ff && !rdy13 |=> v13_ff && $stable(cm13_ff), "stalled scaling stage lost its word")

endmodule

@@ bench/real_spherical_harmonic_eval_top_tb.sv @@
// Self-checking bench for the real spherical harmonic evaluator: directed table, then random points
`timescale 1ns / 100ps

module real_spherical_harmonic_eval_top_tb;
   import rshe_pkg::*;

   localparam int  CYCLE_LIMIT = 400000;
   localparam int  DRAIN_WAIT  = 100;
   localparam int  RAND_POINTS = 1030;
   localparam int  FILL_POINTS = 200;
   localparam logic [63:0] DEC_SCALE = 64'd100000000000000000;

   // one result word as the block should send it
   typedef struct {
      logic [31:0] value;
      status_type  status;
      logic        last;
   } harmonic_t;

   // directed stimulus row; check_fixed selects the typed-in result
   typedef struct {
      logic [31:0] x, y, z;
      logic        last;
      logic [1:0]  deg;
      logic [2:0]  ord;
      bit          check_fixed;
      logic [31:0] value;
      status_type  status;
   } point_row_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   harmonic_t   pending_q[$];
   logic [1:0]  cur_degree;
   logic [2:0]  cur_order;
   bit          calm;
   int          hold_len;
   int          hold_left;
   int          cycles;
   int          mismatches;
   int          points_sent;
   int          words_checked;
   int          status_seen[3];

   real_spherical_harmonic_eval_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   // decimal constant (scaled by 1e17) to Q30, half up
   function automatic logic [63:0] dec_to_q30(input logic [63:0] n);
      logic [63:0] q;
      logic [63:0] r;
      q = n / DEC_SCALE;
      r = n % DEC_SCALE;
      for (int i = 0; i < 30; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= DEC_SCALE) begin
            q = q | 64'd1;
            r = r - DEC_SCALE;
         end
      end
      if ((r << 1) >= DEC_SCALE) q = q + 64'd1;
      return q;
   endfunction

   function automatic logic [63:0] norm_const(input int k);
      logic [63:0] dec;
      case (k)
         0: dec = 64'd28209479177387814;
         1: dec = 64'd48860251190291992;
         2: dec = 64'd109254843059207907;
         3: dec = 64'd31539156525252000;
         4: dec = 64'd54627421529603953;
         5: dec = 64'd59004358992664351;
         6: dec = 64'd289061144264055405;
         7: dec = 64'd45704579946446573;
         8: dec = 64'd37317633259011539;
         default: dec = 64'd144530572132027702;
      endcase
      return dec_to_q30(dec);
   endfunction

   function automatic logic [63:0] root_floor(input logic [63:0] n);
      logic [63:0] res;
      logic [63:0] bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n   = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // Q30 times Q30, half away from zero
   function automatic longint q30_mul(input longint a, input longint b);
      longint      p;
      logic [63:0] m;
      longint      q;
      p = a * b;
      m = (p < 0) ? 64'(-p) : 64'(p);
      q = longint'((m + (64'd1 << 29)) >> 30);
      return (p < 0) ? -q : q;
   endfunction

   // constant times polynomial to Q2.29 with saturation
   function automatic logic [31:0] to_output(input int k, input longint poly);
      logic [63:0] m;
      logic [63:0] q;
      m = (poly < 0) ? 64'(-poly) : 64'(poly);
      q = (norm_const(k) * m + (64'd1 << 30)) >> 31;
      if (poly < 0) begin
         if (q > 64'h80000000) q = 64'h80000000;
         return 32'(64'd0 - q);
      end
      if (q > 64'h7FFFFFFF) q = 64'h7FFFFFFF;
      return q[31:0];
   endfunction

   function automatic harmonic_t predict_harmonic(input logic [31:0] cx, input logic [31:0] cy,
                                                  input logic [31:0] cz, input logic lst,
                                                  input logic [1:0] deg, input logic [2:0] ord);
      harmonic_t   res;
      logic [31:0] c[3];
      logic [63:0] mag[3];
      bit          neg[3];
      longint      u[3];
      logic [63:0] orv, r2, r;
      int          m, am, len, k;
      longint      one, zz, poly;
      c[0] = cx; c[1] = cy; c[2] = cz;
      one  = longint'(1) << 30;
      m    = $signed(ord);
      am   = (m < 0) ? -m : m;
      orv  = 0;
      r2   = 0;
      len  = 0;
      k    = 0;
      poly = 0;
      res.last   = lst;
      res.status = ST_OK;
      res.value  = '0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = c[i][31];
         mag[i] = neg[i] ? 64'({1'b0, ~c[i]} + 33'd1) : 64'(c[i]);
         orv    = orv | mag[i];
      end
      if (deg == 0) begin
         res.value = to_output(0, one);
         return res;
      end
      if (orv == 0) begin
         res.status = ST_ORIGIN;
         return res;
      end
      if (am > deg) begin
         res.status = ST_BAD_ORDER;
         return res;
      end
      while (len < 64 && (orv >> len) != 0) len++;
      for (int i = 0; i < 3; i++) begin
         if (len > 31) mag[i] = mag[i] >> (len - 31);
         else mag[i] = mag[i] << (31 - len);
         r2 = r2 + mag[i] * mag[i];
      end
      r = root_floor(r2);
      for (int i = 0; i < 3; i++) begin
         u[i] = longint'(((mag[i] << 30) + (r >> 1)) / r);
         if (neg[i]) u[i] = -u[i];
      end
      zz = q30_mul(u[2], u[2]);
      if (deg == 1) begin
         k    = 1;
         poly = (m < 0) ? -u[1] : (m == 0) ? u[2] : -u[0];
      end else if (deg == 2) begin
         case (m)
            -2: begin k = 2; poly = q30_mul(u[0], u[1]); end
            -1: begin k = 2; poly = -q30_mul(u[1], u[2]); end
            0: begin k = 3; poly = 3 * zz - one; end
            1: begin k = 2; poly = -q30_mul(u[0], u[2]); end
            default: begin k = 4; poly = q30_mul(u[0], u[0]) - q30_mul(u[1], u[1]); end
         endcase
      end else begin
         case (m)
            -3: begin
               k = 5;
               poly = q30_mul(3 * q30_mul(u[0], u[0]) - q30_mul(u[1], u[1]), u[1]);
            end
            -2: begin k = 6; poly = q30_mul(q30_mul(u[0], u[1]), u[2]); end
            -1: begin k = 7; poly = q30_mul(u[1], 5 * zz - one); end
            0: begin k = 8; poly = q30_mul(u[2], 5 * zz - 3 * one); end
            1: begin k = 7; poly = q30_mul(u[0], 5 * zz - one); end
            2: begin
               k = 9;
               poly = q30_mul(q30_mul(u[0], u[0]) - q30_mul(u[1], u[1]), u[2]);
            end
            default: begin
               k = 5;
               poly = q30_mul(q30_mul(u[0], u[0]) - 3 * q30_mul(u[1], u[1]), u[0]);
            end
         endcase
      end
      res.value = to_output(k, poly);
      return res;
   endfunction

   // ---------------------------------------------------------------- drivers

   // wait for the pipe to empty, then program degree and order back to back
   task automatic program_mode(input logic [1:0] deg, input logic [2:0] ord);
      wait (pending_q.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= CSR_DEGREE;
      csr_data  <= CSR_DATA_W'(deg);
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_ORDER;
      csr_data  <= ord;
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      cur_degree = deg;
      cur_order  = ord;
   endtask

   // offer one point; the expectation is queued when the word is taken
   task automatic send_point(input logic [31:0] cx, input logic [31:0] cy,
                             input logic [31:0] cz, input logic lst,
                             input bit fixed, input harmonic_t fixed_res);
      // one idle cycle before about a third of the words: roughly 26 idle in 100
      if (!calm && $urandom_range(0, 99) < 35) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {cz, cy, cx};
      req_tlast  <= lst;
      do @(posedge clock); while (!req_tready);
      pending_q.push_back(fixed ? fixed_res
                          : predict_harmonic(cx, cy, cz, lst, cur_degree, cur_order));
      points_sent++;
   endtask

   task automatic stop_sending();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   // random coordinate: full range, scaled down, axis-like or extreme
   function automatic logic [31:0] rand_coord(input int kind);
      logic [31:0] v;
      v = $urandom;
      case (kind)
         0, 1, 2: ;
         3, 4: v = $signed(v) >>> $urandom_range(1, 31);
         5: v = ($urandom_range(0, 1) == 0) ? 32'd0 : v;
         default: begin
            case ($urandom_range(0, 4))
               0: v = 32'h80000000;
               1: v = 32'h7FFFFFFF;
               2: v = 32'd1;
               3: v = 32'hFFFFFFFF;
               default: v = 32'd0;
            endcase
         end
      endcase
      return v;
   endfunction

   // ---------------------------------------------------------------- result checker

   always @(posedge clock) begin
      harmonic_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected result word value=%h status=%0d last=%b",
                        rsp_tdata, rsp_tuser, rsp_tlast);
         end else begin
            want = pending_q.pop_front();
            words_checked++;
            if (want.status <= ST_BAD_ORDER) status_seen[want.status]++;
            if (rsp_tdata !== want.value || rsp_tuser !== want.status
                || rsp_tlast !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: word %0d exp value=%h status=%0d last=%b, got %h %0d %b",
                           words_checked, want.value, want.status, want.last,
                           rsp_tdata, rsp_tuser, rsp_tlast);
            end
         end
      end
   end

   // receiver: random hold-off, plus a long counted stall on request
   always @(posedge clock) begin
      if (hold_len > 0) begin
         hold_left = hold_len;
         hold_len  = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 26);
      end
   end

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus

   point_row_t rows[$];

   function automatic point_row_t mk_row(input logic [31:0] x, input logic [31:0] y,
                                         input logic [31:0] z, input logic lst,
                                         input logic [1:0] deg, input logic [2:0] ord,
                                         input bit fixed, input status_type st);
      point_row_t r;
      r.x = x; r.y = y; r.z = z; r.last = lst;
      r.deg = deg; r.ord = ord;
      r.check_fixed = fixed;
      r.value = '0;
      r.status = st;
      return r;
   endfunction

   initial begin
      harmonic_t  fixed_res;
      point_row_t row;
      int         kind, batch, cnt;
      logic [31:0] px, py, pz;
      cur_degree = 0;
      cur_order  = 0;
      calm = 0;
      hold_len = 0;
      hold_left = 0;
      cycles = 0;
      mismatches = 0;
      points_sent = 0;
      words_checked = 0;

      // constant for degree zero, any point and order, origin included
      rows.push_back(mk_row(0, 0, 0, 0, 0, 0, 0, ST_OK));
      rows.push_back(mk_row(32'h7FFFFFFF, 32'h80000000, 5, 1, 0, 3'b100, 0, ST_OK));
      // origin status, also where it wins over a bad order
      rows.push_back(mk_row(0, 0, 0, 1, 1, 0, 1, ST_ORIGIN));
      rows.push_back(mk_row(0, 0, 0, 0, 3, 3'b100, 1, ST_ORIGIN));
      // order out of range
      rows.push_back(mk_row(1, 0, 0, 0, 1, 3'b100, 1, ST_BAD_ORDER));
      rows.push_back(mk_row(0, 32'h80000000, 0, 1, 1, 2, 1, ST_BAD_ORDER));
      rows.push_back(mk_row(7, 7, 7, 0, 2, 3, 1, ST_BAD_ORDER));
      rows.push_back(mk_row(7, 7, 7, 0, 2, 3'b101, 1, ST_BAD_ORDER));
      // extremes through each degree and order
      rows.push_back(mk_row(0, 0, 32'h7FFFFFFF, 0, 1, 0, 0, ST_OK));
      rows.push_back(mk_row(0, 0, 32'h80000000, 0, 1, 0, 0, ST_OK));
      rows.push_back(mk_row(32'h80000000, 32'h80000000, 32'h80000000, 1, 1, 1, 0, ST_OK));
      rows.push_back(mk_row(32'hFFFFFFFF, 1, 0, 0, 1, 3'b111, 0, ST_OK));
      for (int o = -2; o <= 2; o++)
         rows.push_back(mk_row(32'h7FFFFFFF, 32'hFFFFFFFF, 32'h80000000, o[0], 2, 3'(o), 0, ST_OK));
      for (int o = -3; o <= 3; o++)
         rows.push_back(mk_row(3, 32'hFFFFFFFE, 1, o[0], 3, 3'(o), 0, ST_OK));
      rows.push_back(mk_row(32'h12345678, 32'h80000000, 32'h7FFFFFFF, 1, 3, 3, 0, ST_OK));

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (rows[i]) begin
         row = rows[i];
         if (row.deg != cur_degree || row.ord != cur_order) begin
            stop_sending();
            program_mode(row.deg, row.ord);
         end
         fixed_res.value  = row.value;
         fixed_res.status = row.status;
         fixed_res.last   = row.last;
         send_point(row.x, row.y, row.z, row.last, row.check_fixed, fixed_res);
      end
      stop_sending();

      // random batches across all degree and order settings
      batch = 0;
      while (points_sent < RAND_POINTS + rows.size()) begin
         stop_sending();
         program_mode(2'($urandom_range(0, 3)), 3'($urandom));
         calm = (batch == 3);
         if (batch == 6) hold_len = 300;
         // the stalled batch is long enough to fill the whole pipe
         cnt = (batch == 6) ? FILL_POINTS : int'($urandom_range(20, 50));
         for (int n = 0; n < cnt; n++) begin
            kind = $urandom_range(0, 7);
            px = rand_coord(kind);
            py = rand_coord(kind);
            pz = rand_coord(kind);
            if ($urandom_range(0, 40) == 0) begin
               px = 0; py = 0; pz = 0;
            end
            send_point(px, py, pz, (n == cnt - 1) || ($urandom_range(0, 15) == 0),
                       0, fixed_res);
            // sender pause until the pipe drains
            if (batch == 9 && n == 10) begin
               stop_sending();
               wait (pending_q.size() == 0);
            end
         end
         calm = 0;
         batch++;
      end
      stop_sending();

      wait (pending_q.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("Covered %0d points over %0d mode settings: %0d ok, %0d origin, %0d bad order.",
               points_sent, batch, status_seen[0], status_seen[1], status_seen[2]);
      $display("Included a long result stall, a drain pause and a stretch at full rate.");
      if (mismatches == 0 && words_checked == points_sent) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
